// ===== sv/rme_pkg.sv =====
package rme_pkg;

  // widths of the datapath
  localparam int ELEM_W = 18;
  localparam int OPER_W = 19;
  localparam int SQ_W = 38;
  localparam int CX_W = 36;
  localparam int CZ_W = 35;
  localparam int SQRT_CELLS = 19;
  localparam int TAB_LEN = 24;
  localparam int PRESCALE_SH = 12;
  localparam longint PI_Q30 = 64'd3373259426;

  // atan(2^-i) in q30
  localparam longint ATAN_TAB [TAB_LEN] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687,  33543516,  16775851,  8388437,
    4194283,   2097149,   1048576,   524288,
    262144,    131072,    65536,     32768,
    16384,     8192,      4096,      2048,
    1024,      512,       256,       128
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
  } rme_mat_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } rme_sq_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } rme_lane_t;

  typedef struct packed {
    logic       vld;
    logic       sing;
    logic [2:0] zero;
  } rme_ctl_t;

  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    atan_q30 = CZ_W'(ATAN_TAB[i]);
  endfunction

endpackage

// ===== sv/rme_sqrt_cell.sv =====
module rme_sqrt_cell #(
  parameter int K = 18
) (
  input  logic              clk,
  input  rme_pkg::rme_sq_t  sq_in,
  input  rme_pkg::rme_mat_t mat_in,
  output rme_pkg::rme_sq_t  sq_out,
  output rme_pkg::rme_mat_t mat_out
);

  localparam logic [rme_pkg::SQ_W-1:0] BIT = rme_pkg::SQ_W'(1) << (2 * K);

  rme_pkg::rme_sq_t  sq_r, sq_nxt;
  rme_pkg::rme_mat_t mat_r;
  logic [rme_pkg::SQ_W-1:0] trial;

  // one result bit of the digit-by-digit root
  always_comb begin
    trial = sq_in.res + BIT;
    if (sq_in.n >= trial) begin
      sq_nxt.n = sq_in.n - trial;
      sq_nxt.res = (sq_in.res >> 1) + BIT;
    end else begin
      sq_nxt.n = sq_in.n;
      sq_nxt.res = sq_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    mat_r <= mat_in;
  end

  assign sq_out = sq_r;
  assign mat_out = mat_r;

endmodule

// ===== sv/rme_cordic_cell.sv =====
module rme_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  rme_pkg::rme_lane_t lane_in,
  output rme_pkg::rme_lane_t lane_out
);

  rme_pkg::rme_lane_t lane_r, lane_nxt;
  logic signed [rme_pkg::CX_W-1:0] xs, ys;

  // one vectoring micro-rotation
  always_comb begin
    xs = lane_in.x >>> STEP;
    ys = lane_in.y >>> STEP;
    if (!lane_in.y[rme_pkg::CX_W-1]) begin
      lane_nxt.x = lane_in.x + ys;
      lane_nxt.y = lane_in.y - xs;
      lane_nxt.z = lane_in.z + rme_pkg::atan_q30(STEP);
    end else begin
      lane_nxt.x = lane_in.x - ys;
      lane_nxt.y = lane_in.y + xs;
      lane_nxt.z = lane_in.z - rme_pkg::atan_q30(STEP);
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule

// ===== sv/rotation_matrix_to_euler.sv =====
// rotation matrix to x-y-z euler angles
// input: drive the seven matrix elements (signed q2.16) with start high;
// busy is always low, so an item is taken at every edge where start is high.
// output: out_valid strobes for one cycle with angle_x/y/z (signed radians
// with ANGLE_FRAC_BITS fraction bits) and the singular flag. the receiver
// cannot stall; every result appears exactly once, in input order.
// pipeline: registered stages from the accepting edge to the edge that samples
// out_valid: squaring, sum, 19 root cells, operand setup, one cordic cell per
// step, rounding. throughput is one item per cycle, set by the row of root
// cells and the three rows of cordic cells that all advance each cycle.
// configuration: cfg_we writes cfg_wdata into the singular threshold
// (unsigned q1.16, reset 1 lsb); write it only while no items are in flight.
// reset: rst_n low clears the pipeline valid bits and returns the threshold
// to 1 lsb; items in flight are dropped and no strobe follows until new items arrive.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [17:0] in_r00,
  input  logic [17:0] in_r10,
  input  logic [17:0] in_r11,
  input  logic [17:0] in_r12,
  input  logic [17:0] in_r20,
  input  logic [17:0] in_r21,
  input  logic [17:0] in_r22,
  output logic        out_valid,
  output logic [15:0] out_angle_x,
  output logic [15:0] out_angle_y,
  output logic [15:0] out_angle_z,
  output logic        out_singular,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  localparam int NSQ = rme_pkg::SQRT_CELLS;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [rme_pkg::CX_W-1:0] HALF =
    rme_pkg::CX_W'(64'd1 << (SH - 1));
  localparam logic signed [rme_pkg::CX_W-1:0] LIM =
    rme_pkg::CX_W'((rme_pkg::PI_Q30 + (64'd1 << (SH - 1))) >> SH);

  logic [16:0] thr_r;
  logic        v1_r, v2_r;
  rme_pkg::rme_mat_t mat1_r, mat2_r, mat_in;
  logic [35:0] p00_r, p10_r;
  logic [rme_pkg::SQ_W-1:0] sum_r;
  logic [NSQ-1:0] sqv_r;

  rme_pkg::rme_sq_t  sq [NSQ+1];
  rme_pkg::rme_mat_t mat [NSQ+1];

  rme_pkg::rme_ctl_t ctl_r [CORDIC_STEPS+1];
  rme_pkg::rme_lane_t lx [CORDIC_STEPS+1];
  rme_pkg::rme_lane_t ly [CORDIC_STEPS+1];
  rme_pkg::rme_lane_t lz [CORDIC_STEPS+1];
  rme_pkg::rme_lane_t lx_nxt, ly_nxt, lz_nxt;
  rme_pkg::rme_ctl_t  ctl_nxt;

  logic signed [rme_pkg::OPER_W-1:0] sy, ny20, ny12, xa_y, xa_x;
  logic [18:0] sy_u;
  logic        sing;

  logic        ov_r, os_r;
  logic [15:0] ox_r, oy_r, oz_r;

  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 17'd1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign mat_in = '{r00: in_r00, r10: in_r10, r11: in_r11, r12: in_r12,
                    r20: in_r20, r21: in_r21, r22: in_r22};

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mat1_r <= mat_in;
    p00_r <= 36'($signed(in_r00) * $signed(in_r00));
    p10_r <= 36'($signed(in_r10) * $signed(in_r10));
    mat2_r <= mat1_r;
    sum_r <= rme_pkg::SQ_W'(p00_r) + rme_pkg::SQ_W'(p10_r);
  end

  // row of square root cells
  assign sq[0] = '{n: sum_r, res: '0};
  assign mat[0] = mat2_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    rme_sqrt_cell #(.K(NSQ - 1 - k)) u_cell (
      .clk    (clk),
      .sq_in  (sq[k]),
      .mat_in (mat[k]),
      .sq_out (sq[k+1]),
      .mat_out(mat[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r <= '0;
    end else begin
      sqv_r <= {sqv_r[NSQ-2:0], v2_r};
    end
  end

  // quadrant fold and prescale of one atan2 operand pair
  function automatic rme_pkg::rme_lane_t fold(
    input logic signed [rme_pkg::OPER_W-1:0] yin,
    input logic signed [rme_pkg::OPER_W-1:0] xin
  );
    rme_pkg::rme_lane_t l;
    logic signed [rme_pkg::CX_W-1:0] xe, ye;
    xe = {{(rme_pkg::CX_W - rme_pkg::OPER_W){xin[rme_pkg::OPER_W-1]}}, xin}
         <<< rme_pkg::PRESCALE_SH;
    ye = {{(rme_pkg::CX_W - rme_pkg::OPER_W){yin[rme_pkg::OPER_W-1]}}, yin}
         <<< rme_pkg::PRESCALE_SH;
    if (xe[rme_pkg::CX_W-1]) begin
      l.x = -xe;
      l.y = -ye;
      l.z = ye[rme_pkg::CX_W-1] ? -rme_pkg::CZ_W'(rme_pkg::PI_Q30)
                                : rme_pkg::CZ_W'(rme_pkg::PI_Q30);
    end else begin
      l.x = xe;
      l.y = ye;
      l.z = '0;
    end
    fold = l;
  endfunction

  // singular decision and operand setup
  always_comb begin
    sy_u = sq[NSQ].res[18:0];
    sy = $signed(sy_u);
    sing = sy_u < {2'b00, thr_r};
    ny20 = -{mat[NSQ].r20[17], mat[NSQ].r20};
    ny12 = -{mat[NSQ].r12[17], mat[NSQ].r12};
    if (sing) begin
      xa_y = ny12;
      xa_x = {mat[NSQ].r11[17], mat[NSQ].r11};
    end else begin
      xa_y = {mat[NSQ].r21[17], mat[NSQ].r21};
      xa_x = {mat[NSQ].r22[17], mat[NSQ].r22};
    end
    lx_nxt = fold(xa_y, xa_x);
    ly_nxt = fold(ny20, sy);
    lz_nxt = fold({mat[NSQ].r10[17], mat[NSQ].r10}, {mat[NSQ].r00[17], mat[NSQ].r00});
    ctl_nxt.vld = sqv_r[NSQ-1];
    ctl_nxt.sing = sing;
    ctl_nxt.zero[0] = (xa_y == '0) && (xa_x == '0);
    ctl_nxt.zero[1] = (ny20 == '0) && (sy == '0);
    ctl_nxt.zero[2] = (mat[NSQ].r10 == '0) && (mat[NSQ].r00 == '0);
  end

  always_ff @(posedge clk) begin
    lx[0] <= lx_nxt;
    ly[0] <= ly_nxt;
    lz[0] <= lz_nxt;
  end

  // control travels beside the cordic rows
  for (genvar s = 0; s <= CORDIC_STEPS; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (s == 0) begin
        ctl_r[s] <= ctl_nxt;
      end else begin
        ctl_r[s] <= ctl_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // three rows of cordic cells
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    rme_cordic_cell #(.STEP(s)) u_cx (.clk(clk), .lane_in(lx[s]), .lane_out(lx[s+1]));
    rme_cordic_cell #(.STEP(s)) u_cy (.clk(clk), .lane_in(ly[s]), .lane_out(ly[s+1]));
    rme_cordic_cell #(.STEP(s)) u_cz (.clk(clk), .lane_in(lz[s]), .lane_out(lz[s+1]));
  end

  // round half up and saturate to +-pi; a flagged zero operand pair gives 0
  function automatic logic [15:0] to_angle(
    input logic signed [rme_pkg::CZ_W-1:0] z,
    input logic zero
  );
    logic signed [rme_pkg::CX_W-1:0] a;
    a = ($signed({z[rme_pkg::CZ_W-1], z}) + HALF) >>> SH;
    if (a > LIM) a = LIM;
    if (a < -LIM) a = -LIM;
    to_angle = zero ? 16'd0 : a[15:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ctl_r[CORDIC_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    os_r <= ctl_r[CORDIC_STEPS].sing;
    ox_r <= to_angle(lx[CORDIC_STEPS].z, ctl_r[CORDIC_STEPS].zero[0]);
    oy_r <= to_angle(ly[CORDIC_STEPS].z, ctl_r[CORDIC_STEPS].zero[1]);
    oz_r <= to_angle(lz[CORDIC_STEPS].z,
                     ctl_r[CORDIC_STEPS].zero[2] | ctl_r[CORDIC_STEPS].sing);
  end

  assign out_valid = ov_r;
  assign out_singular = os_r;
  assign out_angle_x = ox_r;
  assign out_angle_y = oy_r;
  assign out_angle_z = oz_r;

endmodule

// ===== sv/rme_checker.sv =====
module rme_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_singular,
  input logic [15:0] out_angle_z
);

  localparam int LAT = 23 + CORDIC_STEPS;

  // block never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted item is followed by a strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing");

  // no strobe without an item
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("unexpected result");

  // singular result has zero z angle
  a_sing_z: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_angle_z == 16'd0))
    else $error("z not zero when singular");

endmodule

bind rotation_matrix_to_euler rme_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_rme_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_singular(out_singular),
  .out_angle_z (out_angle_z)
);
